// ===== design/jvss_pkg.sv =====
// ============================================================================
// JSON value skip scanner package
// Shared constants, status codes and control types for the skip scanner.
// ============================================================================
package jvss_pkg;

    // Deepest nesting that the kind stack holds
    localparam int MAX_NEST = 64;
    // Width of the nesting level register (holds 0 .. MAX_NEST)
    localparam int NEST_W   = $clog2(MAX_NEST + 1);
    // Width of the reported nesting level
    localparam int LEVEL_W  = 7;

    // Character codes
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_OBJ_OPEN  = 8'h7B;
    localparam logic [7:0] CH_ARR_OPEN  = 8'h5B;
    localparam logic [7:0] CH_OBJ_CLOSE = 8'h7D;
    localparam logic [7:0] CH_ARR_CLOSE = 8'h5D;
    localparam logic [7:0] CH_EOT       = 8'h00;

    // Result status codes
    typedef enum logic [2:0] {
        ST_SCAN     = 3'd0,
        ST_COMMA    = 3'd1,
        ST_CLOSE    = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_EOT      = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_IDLE     = 3'd6
    } t_status;

    // Shift control for the kind stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    // One result transaction
    typedef struct packed {
        t_status              status;
        logic                 byte_consumed;
        logic [LEVEL_W-1:0]   nest_level_out;
    } t_result;

endpackage

// ===== design/jvss_in_if.sv =====
// ============================================================================
// Skip scanner input channel
// Valid/ready channel carrying one JSON text byte and its start flags.
// ============================================================================
interface jvss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       first;
    logic       enclosing_is_array;

    modport source (output valid, output text_byte, output first,
                    output enclosing_is_array, input ready);
    modport sink   (input valid, input text_byte, input first,
                    input enclosing_is_array, output ready);
endinterface

// ===== design/jvss_out_if.sv =====
// ============================================================================
// Skip scanner result channel
// Valid/ready channel carrying the status of one scanned byte.
// ============================================================================
interface jvss_out_if
    import jvss_pkg::*;
;
    logic               valid;
    logic               ready;
    t_status            status;
    logic               byte_consumed;
    logic [LEVEL_W-1:0] nest_level_out;

    modport source (output valid, output status, output byte_consumed,
                    output nest_level_out, input ready);
    modport sink   (input valid, input status, input byte_consumed,
                    input nest_level_out, output ready);
endinterface

// ===== design/jvss_stack_cell.sv =====
// ============================================================================
// Kind stack cell
// One bit of the bracket kind stack; shifts toward the top on pop and away
// from it on push, trading its bit with its neighbors.
// ============================================================================
module jvss_stack_cell
    import jvss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stack_ctl i_ctl,
    input  logic       i_from_upper,   // neighbor nearer the top (or new kind)
    input  logic       i_from_lower,   // neighbor further down (or zero)
    output logic       o_kind
);

    logic r_kind;
    logic n_kind;

    // push takes the upper bit, pop takes the lower bit
    always_comb begin
        n_kind = r_kind;
        if (i_ctl.push) begin
            n_kind = i_from_upper;
        end else if (i_ctl.pop) begin
            n_kind = i_from_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b0;
        end else begin
            r_kind <= n_kind;
        end
    end

    assign o_kind = r_kind;

endmodule

// ===== design/jvss_out_skid.sv =====
// ============================================================================
// Result output stage
// Output register plus one skid entry so the scanner keeps taking bytes
// while a finished result waits on the receiver.
// ============================================================================
module jvss_out_skid
    import jvss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_can_push,
    jvss_out_if.source o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop        = r_out_valid && o_res.ready;
    assign o_can_push = !r_skid_valid;

    // control: skid entry drains first, new results fill the free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (r_out_valid && !pop) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out.status;
    assign o_res.byte_consumed  = r_out.byte_consumed;
    assign o_res.nest_level_out = r_out.nest_level_out;

endmodule

// ===== design/json_value_skip_scanner_unit.sv =====
// ============================================================================
// JSON value skip scanner
// Scans JSON text a byte at a time and reports where a skipped value ends.
// ============================================================================
// Usage:
//   i_in  : one text byte per transaction; first=1 starts a new skip and
//           enclosing_is_array gives the container kind around the value.
//   o_res : one result per accepted byte: status, byte_consumed and the
//           nesting level after the byte.
//   i_cfg_we / i_cfg_wdata : write skip_all; change it only while idle.
// Throughput: one byte per cycle while i_in.ready is high. Each byte
//   updates the control registers and shifts the kind stack (a chain of
//   MAX_NEST one-bit cells, top at cell 0) in the cycle it is accepted.
// Output: each result is registered, in the skid entry if o_res is stalled.
// Stall: an output register plus one skid entry buffer results; i_in.ready
//   drops only while both are full and recovers as the receiver drains.
// Reset: synchronous, active low; clears the stack, level, string state,
//   skip_all and both output entries. No clearing pass is needed.
// ============================================================================
module json_value_skip_scanner_unit
    import jvss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    jvss_in_if.sink    i_in,
    jvss_out_if.source o_res
);

    // scanner state
    logic              r_active;
    logic              r_in_string;
    logic [7:0]        r_prev_byte;
    logic              r_outer_kind;
    logic [NEST_W-1:0] r_level;
    logic              r_skip_all;

    logic              n_active;
    logic              n_in_string;
    logic [7:0]        n_prev_byte;
    logic              n_outer_kind;
    logic [NEST_W-1:0] n_level;

    logic              accept;
    logic              can_push;
    t_stack_ctl        stack_ctl;
    logic              push_req;
    logic              pop_req;
    logic              push_kind;
    logic [MAX_NEST-1:0] stack_bits;
    t_result           result;

    // effective state after a possible restart
    logic              e_active;
    logic              e_in_string;
    logic [7:0]        e_prev;
    logic              e_outer;
    logic [NEST_W-1:0] e_level;
    logic              is_open;
    logic              is_close;
    logic              close_kind;
    logic              top_kind;
    logic              toggled;

    assign i_in.ready = can_push;
    assign accept     = i_in.valid && can_push;

    // per-byte scan step
    always_comb begin
        e_active    = r_active;
        e_in_string = r_in_string;
        e_prev      = r_prev_byte;
        e_outer     = r_outer_kind;
        e_level     = r_level;
        if (i_in.first) begin
            e_active    = 1'b1;
            e_in_string = 1'b0;
            e_prev      = 8'h00;
            e_outer     = i_in.enclosing_is_array;
            e_level     = '0;
        end

        is_open    = (i_in.text_byte == CH_OBJ_OPEN) || (i_in.text_byte == CH_ARR_OPEN);
        is_close   = (i_in.text_byte == CH_OBJ_CLOSE) || (i_in.text_byte == CH_ARR_CLOSE);
        close_kind = (i_in.text_byte == CH_ARR_CLOSE);
        top_kind   = (e_level == '0) ? e_outer : stack_bits[0];
        toggled    = e_in_string ^ ((i_in.text_byte == CH_QUOTE) && (e_prev != CH_BACKSLASH));

        n_active     = e_active;
        n_in_string  = e_in_string;
        n_prev_byte  = e_prev;
        n_outer_kind = e_outer;
        n_level      = e_level;
        push_req     = 1'b0;
        pop_req      = 1'b0;
        push_kind    = (i_in.text_byte == CH_ARR_OPEN);
        result.status        = ST_SCAN;
        result.byte_consumed = 1'b1;

        if (!e_active) begin
            result.status        = ST_IDLE;
            result.byte_consumed = 1'b0;
        end else begin
            n_prev_byte = i_in.text_byte;
            if (i_in.text_byte == CH_EOT) begin
                n_active      = 1'b0;
                result.status = ST_EOT;
            end else begin
                n_in_string = toggled;
                if ((i_in.text_byte == CH_QUOTE) || toggled) begin
                    result.status = ST_SCAN;
                end else if ((i_in.text_byte == CH_COMMA) && (e_level == '0)
                             && !r_skip_all) begin
                    n_active      = 1'b0;
                    result.status = ST_COMMA;
                end else if (is_open) begin
                    if (e_level == NEST_W'(MAX_NEST)) begin
                        n_active      = 1'b0;
                        result.status = ST_OVERFLOW;
                    end else begin
                        push_req = 1'b1;
                        n_level  = e_level + NEST_W'(1);
                    end
                end else if (is_close) begin
                    if (top_kind != close_kind) begin
                        n_active      = 1'b0;
                        result.status = ST_MISMATCH;
                    end else if (e_level == '0) begin
                        n_active             = 1'b0;
                        result.status        = ST_CLOSE;
                        result.byte_consumed = 1'b0;
                    end else begin
                        pop_req = 1'b1;
                        n_level = e_level - NEST_W'(1);
                    end
                end
            end
        end
        result.nest_level_out = LEVEL_W'(n_level);
    end

    assign stack_ctl.push = accept && push_req;
    assign stack_ctl.pop  = accept && pop_req;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_in_string  <= 1'b0;
            r_prev_byte  <= 8'h00;
            r_outer_kind <= 1'b0;
            r_level      <= '0;
            r_skip_all   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_skip_all <= i_cfg_wdata;
            end
            if (accept) begin
                r_active     <= n_active;
                r_in_string  <= n_in_string;
                r_prev_byte  <= n_prev_byte;
                r_outer_kind <= n_outer_kind;
                r_level      <= n_level;
            end
        end
    end

    // kind stack: chain of one-bit cells, top at index 0
    for (genvar g = 0; g < MAX_NEST; g++) begin : g_stack
        logic from_upper;
        logic from_lower;
        if (g == 0) begin : g_top
            assign from_upper = push_kind;
        end else begin : g_mid
            assign from_upper = stack_bits[g-1];
        end
        if (g == MAX_NEST - 1) begin : g_bottom
            assign from_lower = 1'b0;
        end else begin : g_up
            assign from_lower = stack_bits[g+1];
        end
        jvss_stack_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (stack_ctl),
            .i_from_upper (from_upper),
            .i_from_lower (from_lower),
            .o_kind       (stack_bits[g])
        );
    end

    // result buffering
    jvss_out_skid u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_result   (result),
        .o_can_push (can_push),
        .o_res      (o_res)
    );

endmodule

// ===== design/jvss_checker.sv =====
// ============================================================================
// Skip scanner port checker
// Watches the result channel of the skip scanner for inconsistent output.
// ============================================================================
module jvss_checker
    import jvss_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input t_status            i_status,
    input logic               i_byte_consumed,
    input logic [LEVEL_W-1:0] i_nest_level_out
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)))
        else $error("result changed while stalled");

    // only a close stop or an ignored byte leaves the byte unread
    a_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_byte_consumed == ((i_status == ST_CLOSE) || (i_status == ST_IDLE))))
        else $error("byte_consumed inconsistent with status");

    // comma and close stops happen at the starting level
    a_stop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && ((i_status == ST_COMMA) || (i_status == ST_CLOSE)))
        |-> (i_nest_level_out == '0))
        else $error("stop reported away from the starting level");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind json_value_skip_scanner_unit jvss_checker u_jvss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_status         (o_res.status),
    .i_byte_consumed  (o_res.byte_consumed),
    .i_nest_level_out (o_res.nest_level_out)
);
